### hw/rtl/byte_budget_lifo_drop_oldest_unit_defines.svh
// Assertion macros shared by the byte budget LIFO RTL.
`ifndef BYTE_BUDGET_LIFO_DROP_OLDEST_UNIT_DEFINES_SVH
`define BYTE_BUDGET_LIFO_DROP_OLDEST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BBL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbl assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BBL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbl assertion failed");

`endif

### hw/rtl/bbl_pkg.sv
// Types, constants and codes of the byte budget LIFO.
package bbl_pkg;

  localparam int ENTRY_DEPTH  = 64;
  localparam int HANDLE_WIDTH = 32;
  localparam int SIZE_W       = 20;
  localparam int IDX_W        = $clog2(ENTRY_DEPTH);
  localparam int CNT_W        = $clog2(ENTRY_DEPTH + 1);
  localparam int OVF_W        = 32;

  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic MAX_BYTES_IDX = 1'b0;
  localparam logic [SIZE_W-1:0] MAX_BYTES_RST = SIZE_W'(65536);

  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(ENTRY_DEPTH - 1);
  localparam logic [IDX_W-1:0] OLDEST_RST = IDX_W'(1 % ENTRY_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(ENTRY_DEPTH);

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK             = 3'd0,
    STAT_INVALID        = 3'd1,
    STAT_CLOSED         = 3'd2,
    STAT_ALREADY_CLOSED = 3'd3,
    STAT_EMPTY          = 3'd4
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    cmd_e                    command;
    logic [SIZE_W-1:0]       entry_size;
    logic [HANDLE_WIDTH-1:0] entry_handle;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic [SIZE_W-1:0]       out_size;
    logic [OVF_W-1:0]        overflow_total;
  } out_item_t;

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] handle;
    logic [SIZE_W-1:0]       size;
  } entry_t;

  // Control bundle from the sequencer to the ring storage.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ring_ctrl_t;

endpackage

### hw/rtl/bbl_alu.sv
// Shared byte-count adder/subtractor with budget compare.
module bbl_alu (
  input  bbl_pkg::alu_op_e          op_i,
  input  logic [bbl_pkg::SIZE_W-1:0] a_i,
  input  logic [bbl_pkg::SIZE_W-1:0] b_i,
  input  logic [bbl_pkg::SIZE_W-1:0] limit_i,
  output logic [bbl_pkg::SIZE_W-1:0] res_o,
  output logic                       over_o
);

  logic [bbl_pkg::SIZE_W:0] wide;

  always_comb begin
    unique case (op_i)
      bbl_pkg::ALU_ADD: wide = {1'b0, a_i} + {1'b0, b_i};
      bbl_pkg::ALU_SUB: wide = {1'b0, a_i} - {1'b0, b_i};
      default:          wide = '0;
    endcase
  end

  assign res_o  = wide[bbl_pkg::SIZE_W-1:0];
  // Full-width sum against the budget; only meaningful for an add.
  assign over_o = wide > {1'b0, limit_i};

endmodule

### hw/rtl/bbl_ring.sv
// Ring storage of (handle, size) entries, one write and one registered read port.
module bbl_ring (
  input  logic                clk_i,
  input  bbl_pkg::ring_ctrl_t ctrl_i,
  input  bbl_pkg::entry_t     wr_data_i,
  output bbl_pkg::entry_t     rd_data_o
);

  bbl_pkg::entry_t mem [bbl_pkg::ENTRY_DEPTH];
  bbl_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[ctrl_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### hw/rtl/byte_budget_lifo_drop_oldest_unit.sv
// Top level of the byte budget LIFO with drop-oldest eviction.
//
// The block keeps up to bbl_pkg::ENTRY_DEPTH (handle, size) entries and
// returns them newest first; the bytes held never exceed max_bytes (APB
// register 0, reset 65536). Every input beat yields exactly one result
// beat. Each item walks the sequencer from IDLE to DONE, and DONE loads
// the result into the output register: close, reserved code, refused
// push and get on an empty store go straight to DONE; a get passes POP
// (one registered ring read); a push passes FIT, then EVICT and FIT again
// for each oldest entry it evicts, because each eviction needs one ring
// read and one pass through the shared byte adder. in_ready_o is high
// only while the sequencer is idle. A finished result waits in the output
// register, so the next command is taken while it is still unclaimed;
// only the result after that stalls until out_ready_i drains the register.
// The ring has no reset: only entries counted as stored are ever read.
// max_bytes may be written only while the block is idle.
`include "byte_budget_lifo_drop_oldest_unit_defines.svh"

module byte_budget_lifo_drop_oldest_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bbl_pkg::in_item_t           in_data_i,

  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bbl_pkg::out_item_t          out_data_o,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbl_pkg::PADDR_W-1:0] paddr,
  input  logic [bbl_pkg::PDATA_W-1:0] pwdata,
  output logic [bbl_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  // Sequencer states: decode in IDLE, fit check / push in FIT, drop the
  // oldest entry in EVICT, finish a get in POP, hand off result in DONE.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIT,
    ST_EVICT,
    ST_POP,
    ST_DONE
  } state_e;

  state_e                             state_q, state_d;
  logic [bbl_pkg::SIZE_W-1:0]         size_q, size_d;
  logic [bbl_pkg::HANDLE_WIDTH-1:0]   handle_q, handle_d;
  bbl_pkg::status_e                   res_status_q, res_status_d;
  logic [bbl_pkg::HANDLE_WIDTH-1:0]   res_handle_q, res_handle_d;
  logic [bbl_pkg::SIZE_W-1:0]         res_size_q, res_size_d;
  logic [bbl_pkg::IDX_W-1:0]          newest_q, newest_d;
  logic [bbl_pkg::IDX_W-1:0]          oldest_q, oldest_d;
  logic [bbl_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [bbl_pkg::SIZE_W-1:0]         stored_q, stored_d;
  logic [bbl_pkg::OVF_W-1:0]          ovf_q, ovf_d;
  logic                               closed_q, closed_d;
  logic [bbl_pkg::SIZE_W-1:0]         max_q;
  bbl_pkg::out_item_t                 out_q, out_d;
  logic                               out_valid_q, out_valid_d;

  logic                               in_acc;
  logic                               cfg_wr;
  logic [bbl_pkg::IDX_W-1:0]          newest_inc, newest_dec, oldest_inc;

  bbl_pkg::alu_op_e                   alu_op;
  logic [bbl_pkg::SIZE_W-1:0]         alu_b;
  logic [bbl_pkg::SIZE_W-1:0]         alu_res;
  logic                               alu_over;

  bbl_pkg::ring_ctrl_t                ring_ctrl;
  bbl_pkg::entry_t                    ring_wr;
  bbl_pkg::entry_t                    ring_rd;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // APB register file: one register, always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == bbl_pkg::MAX_BYTES_IDX);
  always_comb begin
    prdata = '0;
    if (paddr[2] == bbl_pkg::MAX_BYTES_IDX) begin
      prdata = bbl_pkg::PDATA_W'(max_q);
    end
  end

  // Ring index wrap arithmetic; the depth need not be a power of two.
  assign newest_inc = (newest_q == bbl_pkg::IDX_LAST) ? '0 : newest_q + 1'b1;
  assign newest_dec = (newest_q == '0) ? bbl_pkg::IDX_LAST : newest_q - 1'b1;
  assign oldest_inc = (oldest_q == bbl_pkg::IDX_LAST) ? '0 : oldest_q + 1'b1;

  // Shared byte unit: stored + size while fitting, stored - entry otherwise.
  always_comb begin
    if (state_q == ST_FIT) begin
      alu_op = bbl_pkg::ALU_ADD;
      alu_b  = size_q;
    end else begin
      alu_op = bbl_pkg::ALU_SUB;
      alu_b  = ring_rd.size;
    end
  end

  bbl_alu u_alu (
    .op_i    (alu_op),
    .a_i     (stored_q),
    .b_i     (alu_b),
    .limit_i (max_q),
    .res_o   (alu_res),
    .over_o  (alu_over)
  );

  assign ring_wr.handle = handle_q;
  assign ring_wr.size   = size_q;

  bbl_ring u_ring (
    .clk_i     (clk_i),
    .ctrl_i    (ring_ctrl),
    .wr_data_i (ring_wr),
    .rd_data_o (ring_rd)
  );

  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    handle_d     = handle_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_size_d   = res_size_q;
    newest_d     = newest_q;
    oldest_d     = oldest_q;
    cnt_d        = cnt_q;
    stored_d     = stored_q;
    ovf_d        = ovf_q;
    closed_d     = closed_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    ring_ctrl    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          size_d       = in_data_i.entry_size;
          handle_d     = in_data_i.entry_handle;
          res_status_d = bbl_pkg::STAT_OK;
          res_handle_d = '0;
          res_size_d   = '0;
          state_d      = ST_DONE;
          unique case (in_data_i.command)
            bbl_pkg::CMD_PUSH: begin
              // Oversize check wins over the closed check.
              if (in_data_i.entry_size > max_q) begin
                res_status_d = bbl_pkg::STAT_INVALID;
              end else if (closed_q) begin
                res_status_d = bbl_pkg::STAT_CLOSED;
              end else begin
                state_d = ST_FIT;
              end
            end
            bbl_pkg::CMD_GET: begin
              if (cnt_q != '0) begin
                // Fetch the newest entry; data arrives in POP.
                ring_ctrl.rd_en   = 1'b1;
                ring_ctrl.rd_addr = newest_q;
                state_d           = ST_POP;
              end else if (closed_q) begin
                res_status_d = bbl_pkg::STAT_CLOSED;
              end else begin
                res_status_d = bbl_pkg::STAT_EMPTY;
              end
            end
            bbl_pkg::CMD_CLOSE: begin
              if (closed_q) begin
                res_status_d = bbl_pkg::STAT_ALREADY_CLOSED;
              end
              closed_d = 1'b1;
            end
            bbl_pkg::CMD_RSVD: begin
              res_status_d = bbl_pkg::STAT_INVALID;
            end
            default: begin
              res_status_d = bbl_pkg::STAT_INVALID;
            end
          endcase
        end
      end

      ST_FIT: begin
        // Evict while over budget or while the ring is full, else push.
        if (((cnt_q != '0) && alu_over) || (cnt_q == bbl_pkg::CNT_FULL)) begin
          ring_ctrl.rd_en   = 1'b1;
          ring_ctrl.rd_addr = oldest_q;
          state_d           = ST_EVICT;
        end else begin
          ring_ctrl.wr_en   = 1'b1;
          ring_ctrl.wr_addr = newest_inc;
          newest_d          = newest_inc;
          cnt_d             = cnt_q + 1'b1;
          stored_d          = alu_res;
          state_d           = ST_DONE;
        end
      end

      ST_EVICT: begin
        // Drop the oldest entry and recheck the fit.
        stored_d = alu_res;
        cnt_d    = cnt_q - 1'b1;
        ovf_d    = ovf_q + 1'b1;
        oldest_d = oldest_inc;
        state_d  = ST_FIT;
      end

      ST_POP: begin
        stored_d     = alu_res;
        cnt_d        = cnt_q - 1'b1;
        newest_d     = newest_dec;
        res_handle_d = ring_rd.handle;
        res_size_d   = ring_rd.size;
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register is free or being drained.
        if (!out_valid_q || out_ready_i) begin
          out_d.status         = res_status_q;
          out_d.out_handle     = res_handle_q;
          out_d.out_size       = res_size_q;
          out_d.overflow_total = ovf_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      size_q       <= '0;
      handle_q     <= '0;
      res_status_q <= bbl_pkg::STAT_OK;
      res_handle_q <= '0;
      res_size_q   <= '0;
      newest_q     <= '0;
      oldest_q     <= bbl_pkg::OLDEST_RST;
      cnt_q        <= '0;
      stored_q     <= '0;
      ovf_q        <= '0;
      closed_q     <= 1'b0;
      max_q        <= bbl_pkg::MAX_BYTES_RST;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      size_q       <= size_d;
      handle_q     <= handle_d;
      res_status_q <= res_status_d;
      res_handle_q <= res_handle_d;
      res_size_q   <= res_size_d;
      newest_q     <= newest_d;
      oldest_q     <= oldest_d;
      cnt_q        <= cnt_d;
      stored_q     <= stored_d;
      ovf_q        <= ovf_d;
      closed_q     <= closed_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
      if (cfg_wr) begin
        max_q <= pwdata[bbl_pkg::SIZE_W-1:0];
      end
    end
  end

  // Entry count never passes the ring depth.
  `BBL_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= bbl_pkg::CNT_FULL)
  // An empty store holds no bytes.
  `BBL_ASSERT_IMP(a_empty_no_bytes, cnt_q == '0, stored_q == '0)
  // Every eviction counts exactly one overflow.
  `BBL_ASSERT_NXT(a_evict_counts, state_q == ST_EVICT, ovf_q == $past(ovf_q) + 1'b1)
  // An accepted beat always takes the sequencer out of idle.
  `BBL_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready_o)

endmodule
